/* src/mf3_pkg.sv */
// Shared constants and types for the 3x3 median filter.
// No dependencies; imported by the top level, its port checker and the testbench.

package mf3_pkg;

  localparam int PIX_W          = 8;
  localparam int COORD_W        = 10;
  localparam int CFG_W          = 11;
  localparam int WIDTH_RESET    = 640;
  localparam int MIN_WIDTH      = 3;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // stream word widths, padded to whole bytes
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_PAD_W   = OUT_TDATA_W - PIX_W - 2 * COORD_W;

  // one filtered output word
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [PIX_W-1:0]   median;
  } result_t;

  // position of a window center as it moves down the pipeline
  typedef struct packed {
    logic               emit;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } tag_t;

endpackage

/* src/median_filter_3x3_unit.sv */
// 3x3 median filter over a raster pixel stream, top level.
// Depends on mf3_pkg for widths, the result word and the pipeline tag.
//
// Usage:
//   Input stream s_axis_*: one 8-bit pixel per word in raster order;
//   tuser bit 0 marks the first pixel of a frame and restarts the column
//   and row count. Output stream m_axis_*: one word per interior pixel
//   (not in the first or last row or column) with the median of its 3x3
//   neighborhood and the center column and row. Border pixels give no word.
//   cfg_wr_en/cfg_wr_data set the row width in pixels, clamped to
//   [3, MAX_WIDTH]; write it only while the stream is idle.
// Throughput: one pixel per clock unless both output buffer entries are full; set by the
//   single line-store memory, read at acceptance and written back as the pixel moves on.
// Pipeline: a result is registered after the line-store read, window shift, column sort,
//   max/median/min stage and final median into the output buffer.
// Reset: clears the counters, the window and all pipeline valids; the row
//   width returns to 640. The line store is not cleared, since every entry is written
//   in a frame's first two rows before any emitted word depends on it.
// Stall: a two-entry output buffer lets the pipeline take one more word
//   while a result waits; s_axis_tready drops only when both entries are full.

module median_filter_3x3_unit
  import mf3_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration: row width
  input  logic                   cfg_wr_en,
  input  logic [CFG_W-1:0]       cfg_wr_data,
  // pixel input
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] intensity
  input  logic [0:0]             s_axis_tuser,   // [0] frame_start
  // median output
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [7:0] median, [17:8] center_column,
                                                 // [27:18] center_row, [31:28] zero
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = WW + 1;
  localparam int WIDTH_INIT = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

  // compare-exchange helpers for the median network
  function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [PIX_W-1:0] max2(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
    return (a < b) ? b : a;
  endfunction

  function automatic logic [PIX_W-1:0] med3(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // sorted triple, low value in the lowest bits
  function automatic logic [3*PIX_W-1:0] sort3(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b,
                                               input logic [PIX_W-1:0] c);
    logic [PIX_W-1:0] lo, hi, md;
    lo = min2(a, b);
    hi = max2(a, b);
    md = min2(hi, c);
    hi = max2(hi, c);
    return {hi, max2(lo, md), min2(lo, md)};
  endfunction

  function automatic logic [RW-1:0] row_inc(input logic [RW-1:0] r);
    return (32'(r) >= MAX_HEIGHT - 1) ? '0 : r + RW'(1);
  endfunction

  // ---------------------------------------------------------------------
  // row width register
  logic [WW-1:0] width;

  always_ff @(posedge clk) begin
    if (rst) begin
      width <= WW'(WIDTH_INIT);
    end else if (cfg_wr_en) begin
      if (cfg_wr_data < CFG_W'(MIN_WIDTH)) begin
        width <= WW'(MIN_WIDTH);
      end else if (32'(cfg_wr_data) > MAX_WIDTH) begin
        width <= WW'(MAX_WIDTH);
      end else begin
        width <= WW'(cfg_wr_data);
      end
    end
  end

  // ---------------------------------------------------------------------
  // pipeline advance and input handshake
  logic en;
  logic s_fire;
  logic skid_valid;

  assign en            = !skid_valid;
  assign s_axis_tready = en;
  assign s_fire        = s_axis_tvalid && en;

  // ---------------------------------------------------------------------
  // position counters for the incoming pixel
  logic [CW-1:0]   column_count, col_in, col_a;
  logic [RW-1:0]   row_count, row_in, row_a;
  logic [CMPW-1:0] col_b;
  logic [CW-1:0]   col_store;
  logic [RW-1:0]   row_store;
  logic [CW-1:0]   rd_addr;
  tag_t            tag0;

  always_comb begin
    col_in = s_axis_tuser[0] ? '0 : column_count;
    row_in = s_axis_tuser[0] ? '0 : row_count;
    // close the row first if the width shrank under the count
    if (CMPW'(col_in) >= CMPW'(width)) begin
      col_a = '0;
      row_a = row_inc(row_in);
    end else begin
      col_a = col_in;
      row_a = row_in;
    end
    rd_addr = (32'(col_a) >= MAX_WIDTH) ? CW'(MAX_WIDTH - 1) : col_a;
    tag0.emit = (col_a >= CW'(2)) && (row_a >= RW'(2));
    tag0.col  = COORD_W'(32'(col_a) - 32'd1);
    tag0.row  = COORD_W'(32'(row_a) - 32'd1);
    // position of the following pixel
    col_b = CMPW'(col_a) + CMPW'(1);
    if (col_b >= CMPW'(width)) begin
      col_store = '0;
      row_store = row_inc(row_a);
    end else begin
      col_store = CW'(col_b);
      row_store = row_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (s_fire) begin
      column_count <= col_store;
      row_count    <= row_store;
    end
  end

  // ---------------------------------------------------------------------
  // line store: one entry per column, upper row in the high byte
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q;
  logic [2*PIX_W-1:0] byp_q;
  logic               byp_sel;
  logic [2*PIX_W-1:0] rd_pair;
  logic [2*PIX_W-1:0] wr_pair;

  logic               s1_valid;
  logic [CW-1:0]      s1_addr;
  logic [PIX_W-1:0]   s1_pix;
  tag_t               s1_tag;
  logic               s1_fire;

  assign s1_fire = s1_valid && en;
  // a write still in flight to the same column wins over the memory
  assign rd_pair = byp_sel ? byp_q : rd_q;
  assign wr_pair = {rd_pair[PIX_W-1:0], s1_pix};

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      line_mem[s1_addr] <= wr_pair;
    end
    if (s_fire) begin
      rd_q <= line_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      byp_sel <= s1_fire && (s1_addr == rd_addr);
      byp_q   <= wr_pair;
      s1_addr <= rd_addr;
      s1_pix  <= s_axis_tdata[PIX_W-1:0];
      s1_tag  <= tag0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  // ---------------------------------------------------------------------
  // 3x3 window: rows top/middle/bottom, column 2 newest
  logic [PIX_W-1:0] win [9];
  logic             s2_valid;
  tag_t             s2_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (s1_fire) begin
      for (int r = 0; r < 3; r++) begin
        win[r*3]   <= win[r*3+1];
        win[r*3+1] <= win[r*3+2];
      end
      win[2] <= rd_pair[2*PIX_W-1:PIX_W];
      win[5] <= rd_pair[PIX_W-1:0];
      win[8] <= s1_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid && s1_tag.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_tag <= s1_tag;
    end
  end

  // ---------------------------------------------------------------------
  // median stage a: sort each window column
  logic [3*PIX_W-1:0] col_sorted [3];
  logic               s3_valid;
  tag_t               s3_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_tag <= s2_tag;
      for (int k = 0; k < 3; k++) begin
        col_sorted[k] <= sort3(win[k], win[3+k], win[6+k]);
      end
    end
  end

  // median stage b: max of lows, median of middles, min of highs
  logic [PIX_W-1:0] s4_lo, s4_md, s4_hi;
  logic             s4_valid;
  tag_t             s4_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_tag <= s3_tag;
      s4_lo  <= max2(max2(col_sorted[0][PIX_W-1:0], col_sorted[1][PIX_W-1:0]),
                     col_sorted[2][PIX_W-1:0]);
      s4_md  <= med3(col_sorted[0][2*PIX_W-1:PIX_W], col_sorted[1][2*PIX_W-1:PIX_W],
                     col_sorted[2][2*PIX_W-1:PIX_W]);
      s4_hi  <= min2(min2(col_sorted[0][3*PIX_W-1:2*PIX_W], col_sorted[1][3*PIX_W-1:2*PIX_W]),
                     col_sorted[2][3*PIX_W-1:2*PIX_W]);
    end
  end

  // ---------------------------------------------------------------------
  // final median and two-entry output buffer
  result_t new_res;
  result_t out_res, skid_res;
  logic    out_valid;
  logic    push, pop;

  assign new_res.median = med3(s4_lo, s4_md, s4_hi);
  assign new_res.col    = s4_tag.col;
  assign new_res.row    = s4_tag.row;
  assign push           = s4_valid && en;
  assign pop            = out_valid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (push) begin
        out_res <= new_res;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_res <= new_res;
      end else begin
        skid_res <= new_res;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {OUT_PAD_W'(0), out_res};

endmodule

/* src/mf3_checker.sv */
// Port-level checks for the 3x3 median filter, bound to its top level.
// Depends on mf3_pkg for the stream word layout.

module mf3_checker
  import mf3_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // nothing is presented right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output word valid right after reset");

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed or dropped");

  // input backpressure only while a result is waiting
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no pending output");

  // border pixels are never emitted: center coordinates are nonzero
  a_no_border: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[PIX_W+COORD_W-1:PIX_W] != '0) &&
                      (m_axis_tdata[PIX_W+2*COORD_W-1:PIX_W+COORD_W] != '0))
    else $error("border pixel emitted");

endmodule

bind median_filter_3x3_unit mf3_checker u_mf3_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* tb/median_word_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for median_filter_3x3_unit: mirrors the line stores, window and counters,
// predicts every median word from the accepted pixels and checks the output stream.
// Depends on mf3_pkg for stream widths, width limits and the result word layout.

module median_word_checker
  import mf3_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_W-1:0]       cfg_wr_data,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] intensity
  input  logic [0:0]             s_axis_tuser,   // [0] frame_start
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [7:0] median, [17:8] center_column,
                                                 // [27:18] center_row, [31:28] zero
  output int                     mismatch_count,
  output int                     words_due
);

  // shadow copies of the two previous rows and the 3x3 neighborhood
  logic [PIX_W-1:0]      line_two_up [MAX_WIDTH_DEF];
  logic [PIX_W-1:0]      line_one_up [MAX_WIDTH_DEF];
  logic [8:0][PIX_W-1:0] nbhd;
  int unsigned           col_pos;
  int unsigned           row_pos;
  int unsigned           row_width;
  result_t               median_words_q [$];

  function automatic int unsigned clamp_width(input logic [CFG_W-1:0] value);
    if (value < MIN_WIDTH) return MIN_WIDTH;
    if (value > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return 32'(value);
  endfunction

  // the median is the value whose rank range covers the fifth position
  function automatic logic [PIX_W-1:0] median_of_nine(input logic [8:0][PIX_W-1:0] v);
    int below;
    int same;
    for (int i = 0; i < 9; i++) begin
      below = 0;
      same  = 0;
      for (int j = 0; j < 9; j++) begin
        if (v[j] < v[i]) below++;
        else if (v[j] == v[i]) same++;
      end
      if (below <= 4 && below + same >= 5) return v[i];
    end
    return '0;
  endfunction

  function automatic void next_row();
    col_pos = 0;
    row_pos = (row_pos >= MAX_HEIGHT_DEF - 1) ? 0 : row_pos + 1;
  endfunction

  // advance the shadow state by one pixel, queue a word for interior centers
  task automatic filter_pixel(input logic [PIX_W-1:0] pix, input logic sof);
    logic [PIX_W-1:0] above2;
    logic [PIX_W-1:0] above1;
    result_t          w;
    if (sof) begin
      col_pos = 0;
      row_pos = 0;
    end
    // a narrower width may leave the column past the end of the row
    if (col_pos >= row_width) next_row();
    above2 = line_two_up[col_pos];
    above1 = line_one_up[col_pos];
    line_two_up[col_pos] = above1;
    line_one_up[col_pos] = pix;
    for (int r = 0; r < 3; r++) begin
      nbhd[3*r]   = nbhd[3*r+1];
      nbhd[3*r+1] = nbhd[3*r+2];
    end
    nbhd[2] = above2;
    nbhd[5] = above1;
    nbhd[8] = pix;
    if (col_pos >= 2 && row_pos >= 2) begin
      w.median = median_of_nine(nbhd);
      w.col    = COORD_W'(col_pos - 1);
      w.row    = COORD_W'(row_pos - 1);
      median_words_q.push_back(w);
    end
    col_pos++;
    if (col_pos >= row_width) next_row();
  endtask

  task automatic check_median_word(input logic [OUT_TDATA_W-1:0] word);
    result_t got;
    result_t want;
    got = result_t'(word[$bits(result_t)-1:0]);
    if (median_words_q.size() == 0) begin
      if (mismatch_count < 10) $display("unexpected median word %h", word);
      mismatch_count++;
    end else begin
      want = median_words_q.pop_front();
      if (got.median !== want.median || got.col !== want.col || got.row !== want.row ||
          word[OUT_TDATA_W-1 -: OUT_PAD_W] !== '0) begin
        if (mismatch_count < 10)
          $display("median word mismatch: expected median %0d col %0d row %0d, got median %0d col %0d row %0d pad %0h",
                   want.median, want.col, want.row, got.median, got.col, got.row,
                   word[OUT_TDATA_W-1 -: OUT_PAD_W]);
        mismatch_count++;
      end
    end
  endtask

  // watch the ports at each rising edge: output words first, then config, then pixels
  always @(posedge clk) begin
    if (rst) begin
      nbhd      = '0;
      col_pos   = 0;
      row_pos   = 0;
      row_width = WIDTH_RESET;
      median_words_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_median_word(m_axis_tdata);
      if (cfg_wr_en) row_width = clamp_width(cfg_wr_data);
      if (s_axis_tvalid && s_axis_tready) filter_pixel(s_axis_tdata[PIX_W-1:0], s_axis_tuser[0]);
    end
    words_due = median_words_q.size();
  end

endmodule

/* tb/median_filter_3x3_unit_test.sv */
`timescale 1ns / 100ps
// Top of the median_filter_3x3_unit testbench: clock, reset, pixel stimulus,
// output stalls, watchdog and verdict. Depends on mf3_pkg and median_word_checker.

module median_filter_3x3_unit_test;
  import mf3_pkg::*;

  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PIXELS  = 1350;

  typedef enum int {PIX_ANY, PIX_EXTREMES, PIX_NARROW} pix_style_t;
  typedef enum int {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_BLOCKS} rx_pattern_t;

  logic                   clk;
  logic                   rst           = 1'b1;
  logic                   cfg_wr_en     = 1'b0;
  logic [CFG_W-1:0]       cfg_wr_data   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [7:0] intensity
  logic [0:0]             s_axis_tuser  = '0;   // [0] frame_start
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [7:0] median, [17:8] center_column,
                                                // [27:18] center_row, [31:28] zero
  int                     mismatch_count;
  int                     words_due;
  int                     burst_left    = 0;
  int                     pixels_sent   = 0;
  int                     quiet_cycles  = 0;
  int unsigned            rx_cycle      = 0;
  rx_pattern_t            rx_pattern    = RX_ALWAYS;

  median_filter_3x3_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  median_word_checker u_median_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .mismatch_count (mismatch_count),
    .words_due      (words_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // output stalls: the pattern is redrawn at random whenever the low byte of rx_cycle is zero
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle[7:0] == 8'd0) rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
    case (rx_pattern)
      RX_ALWAYS:   m_axis_tready <= 1'b1;
      RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
      RX_PERIODIC: m_axis_tready <= (rx_cycle % 5) < 2;
      default:     m_axis_tready <= rx_cycle[5:4] != 2'd0;
    endcase
  end

  // watchdog on cycles without any word moving
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[median_filter_3x3_unit] ERROR");
      $finish;
    end
  end

  // one pixel word, sent in bursts with random gaps in between
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic sof);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= sof;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    pixels_sent++;
  endtask

  // a run of pixels, optionally opening a frame and with stray frame restarts
  task automatic send_run(input int count, input logic opens_frame, input logic stray_sof,
                          input pix_style_t style);
    logic [PIX_W-1:0] base;
    logic [PIX_W-1:0] pix;
    logic             sof;
    base = PIX_W'($urandom);
    for (int k = 0; k < count; k++) begin
      case (style)
        PIX_EXTREMES: pix = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        PIX_NARROW:   pix = base + PIX_W'($urandom_range(0, 3));
        default:      pix = PIX_W'($urandom);
      endcase
      sof = (k == 0) ? opens_frame : (stray_sof && $urandom_range(0, 99) == 0);
      send_pixel(pix, sof);
    end
  endtask

  // wait until every word is out, then let border pixels clear the pipeline
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (words_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_width(input logic [CFG_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    int               random_start;
    int               roll;
    int               span;
    int               count;
    logic [CFG_W-1:0] raw;
    pix_style_t       style;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // width from reset, two rows and a few pixels into the third
    send_run(2 * WIDTH_RESET + 4, 1'b1, 1'b0, PIX_ANY);
    settle();

    // directed: width below range, alternating extremes, restart in mid-row
    write_width('0);
    send_pixel(8'h00, 1'b1);
    for (int k = 1; k <= 10; k++) send_pixel((k % 2 != 0) ? 8'hFF : 8'h00, 1'b0);
    send_pixel(8'hFF, 1'b1);
    for (int k = 0; k < 8; k++) send_pixel(8'h01 << k, 1'b0);
    settle();

    // width shrunk mid-row closes the row
    write_width(11'd8);
    send_run(2 * 8 + 6, 1'b1, 1'b0, PIX_ANY);
    settle();
    write_width(11'd4);
    send_run(12, 1'b0, 1'b0, PIX_NARROW);
    settle();

    // widths above range clamp to the widest row
    write_width('1);
    send_run(2 * MAX_WIDTH_DEF + 5, 1'b1, 1'b0, PIX_ANY);
    settle();
    write_width(11'd1025);
    send_run(3 * MAX_WIDTH_DEF, 1'b1, 1'b0, PIX_ANY);
    settle();

    // narrow frame tall enough for the row counter to wrap
    write_width(11'd3);
    send_run(3 * (MAX_HEIGHT_DEF + 4), 1'b1, 1'b0, PIX_ANY);
    settle();

    // random frames, mostly narrow, some shrunk partway through
    random_start = pixels_sent;
    while (pixels_sent - random_start < RANDOM_PIXELS) begin
      roll = $urandom_range(0, 31);
      if (roll == 0) raw = CFG_W'($urandom);
      else if (roll == 1) raw = CFG_W'($urandom_range(0, 2));
      else raw = CFG_W'($urandom_range(3, 12));
      span  = (raw < MIN_WIDTH) ? MIN_WIDTH : (raw > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : 32'(raw);
      count = (span > 32) ? 2 * span + $urandom_range(1, 20)
                          : $urandom_range(2 * span + 1, 6 * span + 4);
      style = pix_style_t'($urandom_range(0, 2));
      write_width(raw);
      send_run(count, 1'b1, 1'b1, style);
      if ($urandom_range(0, 3) == 0) begin
        settle();
        // never wider than the rows already stored
        write_width(CFG_W'($urandom_range(0, span)));
        send_run($urandom_range(span, 4 * span), 1'b0, 1'b1, style);
      end
      settle();
    end

    settle();
    if (mismatch_count == 0 && words_due == 0)
      $display("[median_filter_3x3_unit] OK");
    else
      $display("[median_filter_3x3_unit] ERROR");
    $finish;
  end

endmodule
